### rtl/wsr_pkg.sv
// Shared codes and defaults for the WebSocket fragment reassembly checker.
// Used by every module in rtl/; depends on nothing.
`default_nettype none
package wsr_pkg;

  localparam int LEN_BITS_DEF = 16;
  localparam int GEN_BITS_DEF = 8;

  // The configuration register never holds more than 16 bits.
  localparam int CFG_REG_BITS  = 16;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [CFG_REG_BITS-1:0] MAX_LEN_RESET = 16'd4096;

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_LEN = 1'b0;

  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_DATA   = 1'b1;

  localparam logic [1:0] ST_PENDING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_CONFLICT = 2'd3;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;

endpackage
`default_nettype wire

### rtl/wsr_cfg.sv
// APB register block holding the message length limit.
// Depends on wsr_pkg.
`default_nettype none
module wsr_cfg #(
  parameter int LEN_BITS = wsr_pkg::LEN_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [wsr_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [wsr_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic      [wsr_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                    pready,
  output logic [((LEN_BITS < wsr_pkg::CFG_REG_BITS) ? LEN_BITS
                 : wsr_pkg::CFG_REG_BITS)-1:0]    max_len
);
  import wsr_pkg::*;

  localparam int CFG_BITS = (LEN_BITS < CFG_REG_BITS) ? LEN_BITS : CFG_REG_BITS;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= CFG_BITS'(MAX_LEN_RESET);
    end else if (wr_en) begin
      max_len <= pwdata[CFG_BITS-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_LEN: prdata = CFG_DATA_BITS'(max_len);
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/wsr_core.sv
// Reassembly state and the per-beat header and byte checks.
// Depends on wsr_pkg; the state advances only when step is high.
`default_nettype none
module wsr_core #(
  parameter int LEN_BITS = wsr_pkg::LEN_BITS_DEF,
  parameter int GEN_BITS = wsr_pkg::GEN_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [((LEN_BITS < wsr_pkg::CFG_REG_BITS) ? LEN_BITS
                      : wsr_pkg::CFG_REG_BITS)-1:0] max_len,
  input  wire logic                mode,
  input  wire logic [GEN_BITS-1:0] frag_generation,
  input  wire logic [3:0]          frag_opcode,
  input  wire logic [LEN_BITS-1:0] total_len,
  input  wire logic [LEN_BITS-1:0] frag_offset,
  input  wire logic [LEN_BITS-1:0] frag_data_len,
  input  wire logic                data_present,
  input  wire logic [7:0]          data_byte,
  output logic      [1:0]          status,
  output logic                     byte_valid,
  output logic      [7:0]          byte_out,
  output logic      [LEN_BITS-1:0] byte_offset,
  output logic      [3:0]          msg_opcode,
  output logic      [GEN_BITS-1:0] msg_generation,
  output logic      [LEN_BITS-1:0] msg_length
);
  import wsr_pkg::*;

  logic                assembling, assembling_next;
  logic [GEN_BITS-1:0] held_generation, held_generation_next;
  logic [3:0]          held_opcode, held_opcode_next;
  logic [LEN_BITS-1:0] expected_length, expected_length_next;
  logic [LEN_BITS-1:0] received_count, received_count_next;
  logic [LEN_BITS-1:0] bytes_owed, bytes_owed_next;

  logic [LEN_BITS-1:0] lim;
  logic [LEN_BITS-1:0] count_inc;
  logic                bounds_bad;
  logic                first_bad;
  logic                later_bad;

  assign lim       = LEN_BITS'(max_len);
  assign count_inc = received_count + LEN_BITS'(1);

  // The subtraction is only looked at once the offset is known to be in range.
  assign bounds_bad = (lim == '0) || (total_len > lim) || (frag_data_len > lim) ||
                      (frag_offset > total_len) ||
                      (frag_data_len > (total_len - frag_offset)) ||
                      ((frag_data_len != '0) && !data_present);

  assign first_bad = ((frag_opcode != OP_TEXT) && (frag_opcode != OP_BINARY)) ||
                     (frag_offset != '0) || (total_len == '0);

  assign later_bad = (frag_generation != held_generation) ||
                     ((frag_opcode != held_opcode) && (frag_opcode != OP_CONT)) ||
                     (total_len != expected_length) ||
                     (frag_offset != received_count);

  always_comb begin
    assembling_next      = assembling;
    held_generation_next = held_generation;
    held_opcode_next     = held_opcode;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    bytes_owed_next      = bytes_owed;
    status               = ST_PENDING;
    byte_valid           = 1'b0;
    byte_out             = '0;
    byte_offset          = '0;
    msg_opcode           = '0;
    msg_generation       = '0;
    msg_length           = '0;

    if (mode == MODE_HEADER) begin
      if ((bytes_owed != '0) || bounds_bad || (!assembling && first_bad)) begin
        status = ST_INVALID;
      end else if (assembling && later_bad) begin
        status = ST_CONFLICT;
      end else begin
        bytes_owed_next = frag_data_len;
        if (!assembling) begin
          assembling_next      = 1'b1;
          held_generation_next = frag_generation;
          held_opcode_next     = frag_opcode;
          expected_length_next = total_len;
          received_count_next  = '0;
        end
      end
    end else begin
      if ((bytes_owed == '0) || !assembling) begin
        status = ST_INVALID;
      end else begin
        byte_valid          = 1'b1;
        byte_out            = data_byte;
        byte_offset         = received_count;
        received_count_next = count_inc;
        bytes_owed_next     = bytes_owed - LEN_BITS'(1);
        if (count_inc == expected_length) begin
          status         = ST_COMPLETE;
          msg_opcode     = held_opcode;
          msg_generation = held_generation;
          msg_length     = expected_length;
        end
      end
    end

    // Errors and a finished message both drop all reassembly state.
    if (status != ST_PENDING) begin
      assembling_next      = 1'b0;
      held_generation_next = '0;
      held_opcode_next     = OP_CONT;
      expected_length_next = '0;
      received_count_next  = '0;
      bytes_owed_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assembling      <= 1'b0;
      held_generation <= '0;
      held_opcode     <= OP_CONT;
      expected_length <= '0;
      received_count  <= '0;
      bytes_owed      <= '0;
    end else if (step) begin
      assembling      <= assembling_next;
      held_generation <= held_generation_next;
      held_opcode     <= held_opcode_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
      bytes_owed      <= bytes_owed_next;
    end
  end

endmodule
`default_nettype wire

### rtl/websocket_fragment_reassembly_checker.sv
// Top level of the WebSocket fragment reassembly checker: input register,
// result register and the APB limit register. Depends on wsr_pkg, wsr_cfg, wsr_core.
//
//   channel  handshake               payload
//   -------  ----------------------  ------------------------------------------
//   in       in_valid / in_stall     mode, frag_*, total_len, data_*, data_byte
//   out      out_valid / out_stall   status, byte_*, msg_*
//   config   psel/penable/pready     paddr, pwdata, prdata (limit at address 0)
//
// One beat is taken every cycle unless in_stall is high; each beat passes the input
// register, then the checks, into the result register.
// The state and limit are single registers, so the checks are combinational.
// Reset clears the reassembly state and loads the limit with 4096.
// in_stall rises only when the input register is full and the result register
// holds a beat that out_stall keeps from leaving.
`default_nettype none
module websocket_fragment_reassembly_checker #(
  parameter int LEN_BITS = wsr_pkg::LEN_BITS_DEF,
  parameter int GEN_BITS = wsr_pkg::GEN_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [wsr_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [wsr_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic      [wsr_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                    pready,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               mode,
  input  wire logic [GEN_BITS-1:0]                frag_generation,
  input  wire logic [3:0]                         frag_opcode,
  input  wire logic [LEN_BITS-1:0]                total_len,
  input  wire logic [LEN_BITS-1:0]                frag_offset,
  input  wire logic [LEN_BITS-1:0]                frag_data_len,
  input  wire logic                               data_present,
  input  wire logic [7:0]                         data_byte,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [1:0]                         status,
  output logic                                    byte_valid,
  output logic      [7:0]                         byte_out,
  output logic      [LEN_BITS-1:0]                byte_offset,
  output logic      [3:0]                         msg_opcode,
  output logic      [GEN_BITS-1:0]                msg_generation,
  output logic      [LEN_BITS-1:0]                msg_length
);
  import wsr_pkg::*;

  localparam int CFG_BITS = (LEN_BITS < CFG_REG_BITS) ? LEN_BITS : CFG_REG_BITS;

  logic [CFG_BITS-1:0] max_len;

  // Input register.
  logic                in_full, in_full_next;
  logic                in_mode;
  logic [GEN_BITS-1:0] in_generation;
  logic [3:0]          in_opcode;
  logic [LEN_BITS-1:0] in_total;
  logic [LEN_BITS-1:0] in_offset;
  logic [LEN_BITS-1:0] in_data_len;
  logic                in_present;
  logic [7:0]          in_byte;

  logic in_take;
  logic advance;
  logic out_valid_next;

  // Check results before the result register.
  logic [1:0]          c_status;
  logic                c_byte_valid;
  logic [7:0]          c_byte_out;
  logic [LEN_BITS-1:0] c_byte_offset;
  logic [3:0]          c_msg_opcode;
  logic [GEN_BITS-1:0] c_msg_generation;
  logic [LEN_BITS-1:0] c_msg_length;

  wsr_cfg #(
    .LEN_BITS (LEN_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_full_next = in_full;
    if (in_take) begin
      in_full_next = 1'b1;
    end else if (advance) begin
      in_full_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_full   <= in_full_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mode       <= mode;
      in_generation <= frag_generation;
      in_opcode     <= frag_opcode;
      in_total      <= total_len;
      in_offset     <= frag_offset;
      in_data_len   <= frag_data_len;
      in_present    <= data_present;
      in_byte       <= data_byte;
    end
  end

  wsr_core #(
    .LEN_BITS (LEN_BITS),
    .GEN_BITS (GEN_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .max_len         (max_len),
    .mode            (in_mode),
    .frag_generation (in_generation),
    .frag_opcode     (in_opcode),
    .total_len       (in_total),
    .frag_offset     (in_offset),
    .frag_data_len   (in_data_len),
    .data_present    (in_present),
    .data_byte       (in_byte),
    .status          (c_status),
    .byte_valid      (c_byte_valid),
    .byte_out        (c_byte_out),
    .byte_offset     (c_byte_offset),
    .msg_opcode      (c_msg_opcode),
    .msg_generation  (c_msg_generation),
    .msg_length      (c_msg_length)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      status         <= c_status;
      byte_valid     <= c_byte_valid;
      byte_out       <= c_byte_out;
      byte_offset    <= c_byte_offset;
      msg_opcode     <= c_msg_opcode;
      msg_generation <= c_msg_generation;
      msg_length     <= c_msg_length;
    end
  end

endmodule
`default_nettype wire

### tb/wsr_verdict_monitor.sv
// Watches the beat and register channels of the WebSocket fragment reassembly checker,
// predicts one verdict per input beat and compares every output beat against it.
// Depends on wsr_pkg for the mode, opcode, status and register codes.
module wsr_verdict_monitor #(
  parameter int LEN_W = wsr_pkg::LEN_BITS_DEF,
  parameter int GEN_W = wsr_pkg::GEN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [wsr_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [wsr_pkg::CFG_DATA_BITS-1:0] pwdata,
  input  logic [wsr_pkg::CFG_DATA_BITS-1:0] prdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              mode,
  input  logic [GEN_W-1:0]                  frag_generation,
  input  logic [3:0]                        frag_opcode,
  input  logic [LEN_W-1:0]                  total_len,
  input  logic [LEN_W-1:0]                  frag_offset,
  input  logic [LEN_W-1:0]                  frag_data_len,
  input  logic                              data_present,
  input  logic [7:0]                        data_byte,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [1:0]                        status,
  input  logic                              byte_valid,
  input  logic [7:0]                        byte_out,
  input  logic [LEN_W-1:0]                  byte_offset,
  input  logic [3:0]                        msg_opcode,
  input  logic [GEN_W-1:0]                  msg_generation,
  input  logic [LEN_W-1:0]                  msg_length,
  output int                                fail_count,
  output int                                results_owed,
  output int                                headers_taken,
  output int                                data_taken,
  output int                                messages_done,
  output int                                beats_rejected
);
  import wsr_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic             byte_valid;
    logic [7:0]       byte_out;
    logic [LEN_W-1:0] byte_offset;
    logic [3:0]       msg_opcode;
    logic [GEN_W-1:0] msg_generation;
    logic [LEN_W-1:0] msg_length;
  } verdict_t;

  verdict_t verdict_fifo[$];

  logic [CFG_REG_BITS-1:0] len_limit;
  logic                    assembling;
  logic [GEN_W-1:0]        held_gen;
  logic [3:0]              held_op;
  logic [LEN_W-1:0]        want_len;
  logic [LEN_W-1:0]        got_count;
  logic [LEN_W-1:0]        owed_bytes;

  int mismatches = 0;
  int n_headers = 0;
  int n_data = 0;
  int n_done = 0;
  int n_rejected = 0;

  function automatic void drop_message();
    assembling = 1'b0;
    held_gen   = '0;
    held_op    = OP_CONT;
    want_len   = '0;
    got_count  = '0;
    owed_bytes = '0;
  endfunction

  // Applies one beat to the shadow reassembly state and returns the verdict it earns.
  function automatic verdict_t judge_beat(input logic m, input logic [GEN_W-1:0] gen,
                                          input logic [3:0] op, input logic [LEN_W-1:0] tot,
                                          input logic [LEN_W-1:0] off,
                                          input logic [LEN_W-1:0] dlen, input logic pres,
                                          input logic [7:0] b);
    verdict_t v;
    v = '0;
    if (m == MODE_HEADER) begin
      // The offset test guards the subtraction, so the remainder never wraps.
      if (owed_bytes != 0 || len_limit == 0 || tot > len_limit || dlen > len_limit ||
          off > tot || dlen > tot - off || (dlen != 0 && !pres)) begin
        v.status = ST_INVALID;
      end else if (!assembling) begin
        if ((op != OP_TEXT && op != OP_BINARY) || off != 0 || tot == 0) begin
          v.status = ST_INVALID;
        end else begin
          assembling = 1'b1;
          held_gen   = gen;
          held_op    = op;
          want_len   = tot;
          got_count  = '0;
          owed_bytes = dlen;
          v.status   = ST_PENDING;
        end
      end else if (gen != held_gen || (op != held_op && op != OP_CONT) || tot != want_len ||
                   off != got_count) begin
        v.status = ST_CONFLICT;
      end else begin
        owed_bytes = dlen;
        v.status   = ST_PENDING;
      end
    end else if (owed_bytes == 0 || !assembling) begin
      v.status = ST_INVALID;
    end else begin
      v.byte_valid  = 1'b1;
      v.byte_out    = b;
      v.byte_offset = got_count;
      got_count     = got_count + 1'b1;
      owed_bytes    = owed_bytes - 1'b1;
      if (got_count == want_len) begin
        v.status         = ST_COMPLETE;
        v.msg_opcode     = held_op;
        v.msg_generation = held_gen;
        v.msg_length     = want_len;
      end else begin
        v.status = ST_PENDING;
      end
    end
    // Both a finished message and any rejection leave the block idle.
    if (v.status != ST_PENDING) drop_message();
    return v;
  endfunction

  function automatic void match_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    verdict_t                 want;
    verdict_t                 fresh;
    logic [CFG_DATA_BITS-1:0] reg_image;
    if (rst) begin
      drop_message();
      len_limit = MAX_LEN_RESET;
      verdict_fifo.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_MAX_LEN) begin
        if (pwrite) begin
          len_limit = pwdata[CFG_REG_BITS-1:0];
        end else begin
          reg_image = '0;
          reg_image[CFG_REG_BITS-1:0] = len_limit;
          match_field("prdata", reg_image, prdata);
        end
      end
      // Results are retired before new beats are predicted, so a result can never
      // be matched against the beat taken at the same edge.
      if (out_valid && !out_stall) begin
        if (verdict_fifo.size() == 0) begin
          $error("result beat with no input beat waiting for it");
          mismatches++;
        end else begin
          want = verdict_fifo.pop_front();
          match_field("status", want.status, status);
          match_field("byte_valid", want.byte_valid, byte_valid);
          match_field("byte_out", want.byte_out, byte_out);
          match_field("byte_offset", want.byte_offset, byte_offset);
          match_field("msg_opcode", want.msg_opcode, msg_opcode);
          match_field("msg_generation", want.msg_generation, msg_generation);
          match_field("msg_length", want.msg_length, msg_length);
        end
      end
      if (in_valid && !in_stall) begin
        fresh = judge_beat(mode, frag_generation, frag_opcode, total_len, frag_offset,
                           frag_data_len, data_present, data_byte);
        verdict_fifo.push_back(fresh);
        if (mode == MODE_HEADER) n_headers++;
        else n_data++;
        if (fresh.status == ST_COMPLETE) n_done++;
        else if (fresh.status != ST_PENDING) n_rejected++;
      end
    end
    fail_count     <= mismatches;
    results_owed   <= verdict_fifo.size();
    headers_taken  <= n_headers;
    data_taken     <= n_data;
    messages_done  <= n_done;
    beats_rejected <= n_rejected;
  end

endmodule

### tb/tb_websocket_fragment_reassembly_checker.sv
// Testbench top for the WebSocket fragment reassembly checker: clock, reset, register
// writes, fragment and byte stimulus with bursty input and stalling output.
// Depends on wsr_pkg, the block under test and wsr_verdict_monitor.
module tb_websocket_fragment_reassembly_checker;
  import wsr_pkg::*;

  localparam int LEN_W = LEN_BITS_DEF;
  localparam int GEN_W = GEN_BITS_DEF;

  localparam logic [CFG_ADDR_BITS-1:0] MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};
  localparam logic [3:0] OP_UNSUPPORTED = 4'd3;
  // Never a held opcode, so a header carrying it always clears the block.
  localparam logic [3:0] OP_RESYNC = 4'hF;

  typedef enum int {
    FAULT_NONE, FAULT_GEN, FAULT_OPCODE, FAULT_TOTAL, FAULT_OFFSET,
    FAULT_NO_BUFFER, FAULT_OVERSIZE, FAULT_SHORT, FAULT_STRAY
  } fault_e;

  typedef enum int {RX_OPEN, RX_SPOTTY, RX_CHOKED, RX_PERIODIC} rx_style_e;

  logic clk;
  logic rst = 1'b1;

  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             mode = MODE_HEADER;
  logic [GEN_W-1:0] frag_generation = '0;
  logic [3:0]       frag_opcode = OP_CONT;
  logic [LEN_W-1:0] total_len = '0;
  logic [LEN_W-1:0] frag_offset = '0;
  logic [LEN_W-1:0] frag_data_len = '0;
  logic             data_present = 1'b0;
  logic [7:0]       data_byte = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic             byte_valid;
  logic [7:0]       byte_out;
  logic [LEN_W-1:0] byte_offset;
  logic [3:0]       msg_opcode;
  logic [GEN_W-1:0] msg_generation;
  logic [LEN_W-1:0] msg_length;

  int fail_count;
  int results_owed;
  int headers_taken;
  int data_taken;
  int messages_done;
  int beats_rejected;

  int beats_sent = 0;
  int burst_left = 1;
  int settings_used = 0;

  websocket_fragment_reassembly_checker #(.LEN_BITS(LEN_W), .GEN_BITS(GEN_W)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .frag_generation(frag_generation), .frag_opcode(frag_opcode), .total_len(total_len),
    .frag_offset(frag_offset), .frag_data_len(frag_data_len), .data_present(data_present),
    .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .byte_valid(byte_valid),
    .byte_out(byte_out), .byte_offset(byte_offset), .msg_opcode(msg_opcode),
    .msg_generation(msg_generation), .msg_length(msg_length)
  );

  wsr_verdict_monitor #(.LEN_W(LEN_W), .GEN_W(GEN_W)) monitor (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .frag_generation(frag_generation), .frag_opcode(frag_opcode), .total_len(total_len),
    .frag_offset(frag_offset), .frag_data_len(frag_data_len), .data_present(data_present),
    .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .byte_valid(byte_valid),
    .byte_out(byte_out), .byte_offset(byte_offset), .msg_opcode(msg_opcode),
    .msg_generation(msg_generation), .msg_length(msg_length),
    .fail_count(fail_count), .results_owed(results_owed), .headers_taken(headers_taken),
    .data_taken(data_taken), .messages_done(messages_done), .beats_rejected(beats_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  // The receiver switches between open, spotty, choked and periodic stall patterns.
  initial begin : rx_pace
    rx_style_e style;
    int        span;
    int        hold;
    int        tick;
    hold = 0;
    tick = 0;
    forever begin
      style = rx_style_e'($urandom_range(RX_OPEN, RX_PERIODIC));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (style)
          RX_OPEN: out_stall <= 1'b0;
          RX_SPOTTY: out_stall <= ($urandom_range(0, 99) < 30);
          RX_CHOKED: begin
            if (hold == 0 && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 12);
            out_stall <= (hold != 0);
            if (hold != 0) hold--;
          end
          default: out_stall <= (tick % 5 >= 3);
        endcase
      end
    end
  end

  // Holds the beat until it is taken, then either keeps the burst going or idles a while.
  task automatic send_beat(input logic m, input logic [GEN_W-1:0] gen, input logic [3:0] op,
                           input logic [LEN_W-1:0] tot, input logic [LEN_W-1:0] off,
                           input logic [LEN_W-1:0] dlen, input logic pres,
                           input logic [7:0] b);
    int gap;
    in_valid        <= 1'b1;
    mode            <= m;
    frag_generation <= gen;
    frag_opcode     <= op;
    total_len       <= tot;
    frag_offset     <= off;
    frag_data_len   <= dlen;
    data_present    <= pres;
    data_byte       <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 10);
    end
  endtask

  task automatic send_header(input logic [GEN_W-1:0] gen, input logic [3:0] op,
                             input logic [LEN_W-1:0] tot, input logic [LEN_W-1:0] off,
                             input logic [LEN_W-1:0] dlen, input logic pres);
    logic [31:0] r;
    r = $urandom;
    send_beat(MODE_HEADER, gen, op, tot, off, dlen, pres, r[7:0]);
  endtask

  // Header fields are meaningless on a data beat, so they carry random values.
  task automatic send_data(input logic [7:0] b);
    logic [31:0] r1;
    logic [31:0] r2;
    r1 = $urandom;
    r2 = $urandom;
    send_beat(MODE_DATA, r1[GEN_W-1:0], r1[11:8], r1[31:16], r2[15:0], r2[31:16], r1[12], b);
  endtask

  task automatic send_noise();
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    r1 = $urandom;
    r2 = $urandom;
    r3 = $urandom;
    send_beat(r3[0], r1[GEN_W-1:0], r1[11:8], r1[31:16], r2[15:0], r2[31:16], r3[1],
              r3[9:2]);
  endtask

  task automatic send_resync();
    logic [31:0] r1;
    logic [31:0] r2;
    r1 = $urandom;
    r2 = $urandom;
    send_header(r1[GEN_W-1:0], OP_RESYNC, r1[31:16], r2[15:0], r2[31:16], r1[8]);
  endtask

  // Sends one message as up to four fragments; a fault, if any, lands on one fragment
  // header or its bytes, after which the message is abandoned and the block cleared.
  task automatic send_message(input logic [LEN_W-1:0] lim, input fault_e fault);
    logic [31:0]      r;
    logic [GEN_W-1:0] gen;
    logic [GEN_W-1:0] h_gen;
    logic [3:0]       op;
    logic [3:0]       frag_op;
    logic [LEN_W-1:0] cap;
    logic [LEN_W-1:0] tot;
    logic [LEN_W-1:0] got;
    logic [LEN_W-1:0] chunk;
    logic [LEN_W-1:0] h_tot;
    logic [LEN_W-1:0] h_off;
    logic [LEN_W-1:0] h_dlen;
    logic             pres;
    logic             last;
    logic             hit;
    int               k;
    int               n;
    int               fault_frag;
    r = $urandom;
    gen = r[GEN_W-1:0];
    op = r[8] ? OP_TEXT : OP_BINARY;
    cap = (lim > 40) ? LEN_W'(40) : lim;
    if (cap == 0) tot = LEN_W'($urandom_range(1, 8));
    else if ($urandom_range(0, 15) == 0) tot = cap;
    else tot = LEN_W'($urandom_range(1, (cap > 12) ? 12 : cap));
    fault_frag = $urandom_range(0, 2);
    got = '0;
    k = 0;
    hit = 1'b0;
    while (got < tot && !hit) begin
      if (k == 3) chunk = tot - got;
      else if ($urandom_range(0, 6) == 0) chunk = '0;
      else chunk = LEN_W'($urandom_range(1, tot - got));
      last = (got + chunk == tot);
      hit = (fault != FAULT_NONE) && (k == fault_frag || last);
      frag_op = (k == 0 || $urandom_range(0, 1) == 0) ? op : OP_CONT;
      h_gen = gen;
      h_tot = tot;
      h_off = got;
      h_dlen = chunk;
      pres = (chunk != 0) || ($urandom_range(0, 1) == 1);
      n = int'(chunk);
      if (hit) begin
        case (fault)
          FAULT_GEN: h_gen = gen ^ GEN_W'($urandom_range(1, 255));
          FAULT_OPCODE: begin
            if (k != 0) frag_op = (op == OP_TEXT) ? OP_BINARY : OP_TEXT;
            else if ($urandom_range(0, 1) == 0) frag_op = OP_CONT;
            else frag_op = 4'($urandom_range(OP_UNSUPPORTED, 15));
          end
          FAULT_TOTAL: h_tot = tot + LEN_W'($urandom_range(1, 3));
          FAULT_OFFSET: h_off = got + LEN_W'($urandom_range(1, 3));
          FAULT_NO_BUFFER: begin
            pres = 1'b0;
            if (h_dlen == 0) begin
              h_dlen = LEN_W'(1);
              n = 1;
            end
          end
          FAULT_OVERSIZE: h_dlen = (lim == '1) ? lim : lim + 1'b1;
          FAULT_SHORT: if (n > 0) n--;
          default: n++;
        endcase
      end
      send_header(h_gen, frag_op, h_tot, h_off, h_dlen, pres);
      repeat (n) begin
        r = $urandom;
        send_data(r[7:0]);
      end
      got = got + chunk;
      k++;
    end
    if (fault != FAULT_NONE) send_resync();
  endtask

  task automatic reg_access(input logic wr, input logic [CFG_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Returning the bus to idle keeps back-to-back transfers apart.
    @(posedge clk);
  endtask

  // Stops sending and waits for every predicted result, then gives the pipeline time to empty.
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (results_owed != 0 && waited < 4000);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] lim, input int beats);
    logic [CFG_DATA_BITS-1:0] word;
    int                       stop;
    int                       pick;
    settle();
    word = $urandom;
    word[CFG_REG_BITS-1:0] = lim;
    reg_access(1'b1, word);
    reg_access(1'b0, '0);
    settings_used++;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_message(lim, FAULT_NONE);
      end else if (pick < 90) begin
        send_message(lim, fault_e'($urandom_range(FAULT_GEN, FAULT_STRAY)));
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
        send_resync();
      end
    end
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0] mid_limit;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks run under the limit that reset leaves in place.
    reg_access(1'b0, '0);
    settings_used++;
    send_data(8'h5A);                                          // byte with nothing open
    send_header(8'h00, OP_CONT, 16'd4, 16'd0, 16'd0, 1'b0);    // continuation cannot open
    send_header(8'h00, OP_UNSUPPORTED, 16'd4, 16'd0, 16'd0, 1'b0);
    send_header(8'h00, OP_TEXT, 16'd4, 16'd1, 16'd0, 1'b0);    // opening offset not zero
    send_header(8'h00, OP_TEXT, 16'd0, 16'd0, 16'd0, 1'b0);    // empty message
    send_header(8'h00, OP_TEXT, 16'd4, 16'd0, 16'd2, 1'b0);    // data but no buffer
    send_header(8'h00, OP_BINARY, 16'hFFFF, 16'd0, 16'd0, 1'b1);
    send_header(8'h00, OP_BINARY, 16'd4, 16'd5, 16'd0, 1'b1);  // offset past total
    send_header(8'h00, OP_BINARY, 16'd4, 16'd0, 16'd5, 1'b1);  // data overruns total
    // Three fragments, the middle one empty, ending in a completed message.
    send_header(8'hFF, OP_TEXT, 16'd3, 16'd0, 16'd2, 1'b1);
    send_data(8'h00);
    send_data(8'hFF);
    send_header(8'hFF, OP_CONT, 16'd3, 16'd2, 16'd0, 1'b0);
    send_header(8'hFF, OP_TEXT, 16'd3, 16'd2, 16'd1, 1'b1);
    send_data(8'hA5);
    // A header while a byte is still owed.
    send_header(8'h01, OP_BINARY, 16'd2, 16'd0, 16'd2, 1'b1);
    send_data(8'h11);
    send_header(8'h01, OP_CONT, 16'd2, 16'd1, 16'd1, 1'b1);
    // Later fragments that disagree on generation, opcode, total and offset.
    send_header(8'h02, OP_BINARY, 16'd4, 16'd0, 16'd0, 1'b1);
    send_header(8'h03, OP_CONT, 16'd4, 16'd0, 16'd0, 1'b1);
    send_header(8'h02, OP_BINARY, 16'd4, 16'd0, 16'd0, 1'b1);
    send_header(8'h02, OP_TEXT, 16'd4, 16'd0, 16'd0, 1'b1);
    send_header(8'h02, OP_BINARY, 16'd4, 16'd0, 16'd0, 1'b1);
    send_header(8'h02, OP_CONT, 16'd5, 16'd0, 16'd0, 1'b1);
    send_header(8'h02, OP_BINARY, 16'd4, 16'd0, 16'd0, 1'b1);
    send_header(8'h02, OP_CONT, 16'd4, 16'd1, 16'd0, 1'b1);

    mid_limit = LEN_W'($urandom_range(2, 4095));
    run_phase(16'd16, 300);
    run_phase(16'd0, 60);
    run_phase(16'hFFFF, 300);
    run_phase(16'd1, 60);
    run_phase(mid_limit, 200);
    run_phase(MAX_LEN_RESET, 300);
    settle();

    if (results_owed != 0) $error("%0d predicted results never arrived", results_owed);
    $display("Drove %0d header beats and %0d data beats under %0d limit settings.",
             headers_taken, data_taken, settings_used);
    $display("%0d messages reassembled, %0d beats rejected.", messages_done, beats_rejected);
    if (fail_count == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
